FILE: sv/tlc_pkg.sv
package tlc_pkg;

   localparam int AddrBits    = 16;
   localparam int BlockWords  = 16;
   localparam int OffBits     = $clog2(BlockWords);
   localparam int BlkBits     = AddrBits - OffBits;          // 12
   localparam int L1Lines     = 128;
   localparam int L1IdxBits   = $clog2(L1Lines);
   localparam int L2Sets      = 256;
   localparam int SetBits     = $clog2(L2Sets);
   localparam int Ways        = 4;
   localparam int WayBits     = $clog2(Ways);
   localparam int BufDepth    = 4;
   localparam int CntBits     = $clog2(BufDepth + 1);
   localparam int PosBits     = (BufDepth > 1) ? $clog2(BufDepth) : 1;
   localparam int SbBits      = BlkBits + 1;                 // stream entries hold blk+1
   localparam int L1Width     = 2 + BlkBits;                 // valid, dirty, tag
   localparam int L2Width     = Ways * (1 + BlkBits) + Ways * WayBits;

   localparam logic [2:0] OUT_L1_HIT  = 3'd0;
   localparam logic [2:0] OUT_VIC_HIT = 3'd1;
   localparam logic [2:0] OUT_SB_HIT  = 3'd2;
   localparam logic [2:0] OUT_L2_HIT  = 3'd3;
   localparam logic [2:0] OUT_L2_MISS = 3'd4;

   localparam logic [1:0] EVICT_NONE   = 2'd0;
   localparam logic [1:0] EVICT_VICTIM = 2'd1;
   localparam logic [1:0] EVICT_WRITE  = 2'd2;

   typedef struct packed {
      logic [15:0] address;
      logic        is_instruction;
      logic        is_write;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [1:0]  l1_eviction;
      logic        writeback_valid;
      logic [11:0] writeback_block;
      logic [1:0]  l2_way;
   } rsp_type;

   typedef struct packed {
      logic load;      // capture request, start memory reads
      logic clear;     // write one clearing-pass row
      logic resolve;   // read data ready: decide, write back, build result
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } sts_type;

endpackage

FILE: sv/tlc_ram.sv
module tlc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: sv/tlc_ctrl.sv
module tlc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tlc_pkg::cmd_type cmd,
   input  tlc_pkg::sts_type sts
);
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_RESV  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_RESV;
         ST_RESV:  state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) state_in = req_valid ? ST_READ : ST_IDLE;
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall   = !((state_ff == ST_IDLE) || (state_ff == ST_OUT && !rsp_stall));
   assign rsp_valid   = (state_ff == ST_OUT);
   assign cmd.load    = req_valid && !req_stall;
   assign cmd.clear   = (state_ff == ST_CLEAR);
   assign cmd.resolve = (state_ff == ST_RESV);

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_out_after_resolve: assert property (@(posedge clock) disable iff (reset)
      cmd.resolve |=> rsp_valid) else $error("no result after resolve");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> req_stall) else $error("accepted during clear");
endmodule

FILE: sv/tlc_dp.sv
module tlc_dp (
   input  logic             clock,
   input  logic             reset,
   input  tlc_pkg::req_type req_word,
   output tlc_pkg::rsp_type rsp_word,
   input  tlc_pkg::cmd_type cmd,
   output tlc_pkg::sts_type sts
);
   localparam int B = tlc_pkg::BlkBits;
   localparam int W = tlc_pkg::Ways;
   localparam int D = tlc_pkg::BufDepth;
   localparam int WB = tlc_pkg::WayBits;
   localparam int SB = tlc_pkg::SbBits;
   localparam int CB = tlc_pkg::CntBits;
   localparam int LB = tlc_pkg::L1IdxBits;
   localparam int SETB = tlc_pkg::SetBits;
   localparam int MAXB = (LB > SETB) ? LB : SETB;

   // request latch
   logic [B-1:0] blk_ff, blk_in;
   logic         inst_ff, inst_in, wr_ff, wr_in;
   // clearing pass counter
   logic [MAXB:0] clr_ff, clr_in;

   // FIFOs, entry 0 oldest; stream entries are one bit wider
   logic [B-1:0]  vic_ff [D];
   logic [B-1:0]  wbq_ff [D];
   logic [SB-1:0] isb_ff [D];
   logic [SB-1:0] dsb_ff [D];
   logic [B-1:0]  vic_in [D];
   logic [B-1:0]  wbq_in [D];
   logic [SB-1:0] isb_in [D];
   logic [SB-1:0] dsb_in [D];
   logic [CB-1:0] vic_cnt_ff, wbq_cnt_ff, isb_cnt_ff, dsb_cnt_ff;
   logic [CB-1:0] vic_cnt_in, wbq_cnt_in, isb_cnt_in, dsb_cnt_in;

   tlc_pkg::rsp_type rsp_ff, rsp_in;

   // memories
   logic                       l1_we, l2_we;
   logic [LB-1:0]              l1_waddr, l1_raddr;
   logic [SETB-1:0]            l2_waddr, l2_raddr;
   logic [tlc_pkg::L1Width-1:0] l1_wdata, l1_rdata;
   logic [tlc_pkg::L2Width-1:0] l2_wdata, l2_rdata;

   tlc_ram #(.Width(tlc_pkg::L1Width), .Depth(tlc_pkg::L1Lines)) u_l1 (
      .clock, .wr_en(l1_we), .wr_addr(l1_waddr), .wr_data(l1_wdata),
      .rd_addr(l1_raddr), .rd_data(l1_rdata));
   tlc_ram #(.Width(tlc_pkg::L2Width), .Depth(tlc_pkg::L2Sets)) u_l2 (
      .clock, .wr_en(l2_we), .wr_addr(l2_waddr), .wr_data(l2_wdata),
      .rd_addr(l2_raddr), .rd_data(l2_rdata));

   // read the incoming word at accept, then keep reading the latched block
   logic [B-1:0] req_blk;
   assign req_blk  = req_word.address[tlc_pkg::AddrBits-1:tlc_pkg::OffBits];
   assign l1_raddr = cmd.load ? req_blk[LB-1:0] : blk_ff[LB-1:0];
   assign l2_raddr = cmd.load ? req_blk[SETB-1:0] : blk_ff[SETB-1:0];
   assign sts.clear_done = clr_ff[MAXB];

   // decoded L1 / L2 read words
   logic          l1_v, l1_d;
   logic [B-1:0]  l1_tag;
   logic [W-1:0]  l2_v;
   logic [B-1:0]  l2_tag [W];
   logic [WB-1:0] l2_age [W];
   always_comb begin
      {l1_v, l1_d, l1_tag} = l1_rdata;
      for (int w = 0; w < W; w++) begin
         l2_v[w]   = l2_rdata[w*(1+B) + B];
         l2_tag[w] = l2_rdata[w*(1+B) +: B];
         l2_age[w] = l2_rdata[W*(1+B) + w*WB +: WB];
      end
   end

   always_comb begin
      logic          hit_l1, hit_vic, hit_sb, hit_l2, l1_fill;
      logic [CB-1:0] pos, sb_cnt;
      logic [SB-1:0] sb [D];
      logic [WB-1:0] way, old;
      logic [B-1:0]  wv [D];
      logic [CB-1:0] wc;
      logic [tlc_pkg::L2Width-1:0] nl2;

      blk_in = blk_ff; inst_in = inst_ff; wr_in = wr_ff;
      vic_in = vic_ff; wbq_in = wbq_ff; isb_in = isb_ff; dsb_in = dsb_ff;
      vic_cnt_in = vic_cnt_ff; wbq_cnt_in = wbq_cnt_ff;
      isb_cnt_in = isb_cnt_ff; dsb_cnt_in = dsb_cnt_ff;
      rsp_in = rsp_ff;
      clr_in = clr_ff;
      l1_we = 1'b0; l2_we = 1'b0;
      l1_waddr = blk_ff[LB-1:0]; l2_waddr = blk_ff[SETB-1:0];
      l1_wdata = '0; l2_wdata = l2_rdata;
      hit_l1 = 1'b0; hit_vic = 1'b0; hit_sb = 1'b0; hit_l2 = 1'b0;
      l1_fill = 1'b0; pos = '0; way = '0; old = '0;
      if (inst_ff) sb = isb_ff;
      else sb = dsb_ff;
      sb_cnt = inst_ff ? isb_cnt_ff : dsb_cnt_ff;
      wv = wbq_ff; wc = wbq_cnt_ff; nl2 = l2_rdata;

      if (cmd.load) begin
         blk_in  = req_blk;
         inst_in = req_word.is_instruction;
         wr_in   = req_word.is_write;
      end

      if (cmd.clear) begin
         l1_we = 1'b1; l2_we = 1'b1;
         l1_waddr = clr_ff[LB-1:0];
         l2_waddr = clr_ff[SETB-1:0];
         l1_wdata = '0;
         for (int w = 0; w < W; w++) begin
            l2_wdata[w*(1+B) +: 1+B] = '0;
            l2_wdata[W*(1+B) + w*WB +: WB] = WB'(w);
         end
         clr_in = clr_ff + 1'b1;
      end

      if (cmd.resolve) begin
         rsp_in = '0;
         hit_l1 = l1_v && (l1_tag == blk_ff);
         if (hit_l1) begin
            rsp_in.outcome = tlc_pkg::OUT_L1_HIT;
            l1_we = 1'b1;
            l1_wdata = {1'b1, l1_d | wr_ff, blk_ff};
         end else begin
            // oldest matching victim entry
            for (int i = D-1; i >= 0; i--) begin
               if (CB'(i) < vic_cnt_ff && vic_ff[i] == blk_ff) begin
                  hit_vic = 1'b1; pos = CB'(i);
               end
            end
            if (hit_vic) begin
               for (int i = 0; i < D-1; i++)
                  if (CB'(i) >= pos) vic_in[i] = vic_ff[i+1];
               vic_cnt_in = vic_cnt_ff - 1'b1;
               rsp_in.outcome = tlc_pkg::OUT_VIC_HIT;
            end else begin
               for (int i = D-1; i >= 0; i--) begin
                  if (CB'(i) < sb_cnt && sb[i] == {1'b0, blk_ff}) begin
                     hit_sb = 1'b1; pos = CB'(i);
                  end
               end
               if (hit_sb) begin
                  for (int i = 0; i < D-1; i++)
                     if (CB'(i) >= pos) sb[i] = sb[i+1];
                  sb_cnt = sb_cnt - 1'b1;
                  rsp_in.outcome = tlc_pkg::OUT_SB_HIT;
               end else begin
                  for (int w = W-1; w >= 0; w--)
                     if (l2_v[w] && l2_tag[w] == blk_ff) begin
                        hit_l2 = 1'b1; way = WB'(w);
                     end
                  if (!hit_l2) begin
                     for (int w = W-1; w >= 0; w--)
                        if (l2_age[w] == WB'(W-1)) way = WB'(w);
                     for (int w = W-1; w >= 0; w--)
                        if (!l2_v[w]) way = WB'(w);
                     nl2[int'(way)*(1+B) +: 1+B] = {1'b1, blk_ff};
                  end
                  old = l2_age[way];
                  for (int w = 0; w < W; w++) begin
                     if (WB'(w) == way)
                        nl2[W*(1+B) + w*WB +: WB] = '0;
                     else if (l2_age[w] < old)
                        nl2[W*(1+B) + w*WB +: WB] = l2_age[w] + 1'b1;
                  end
                  l2_we = 1'b1; l2_wdata = nl2;
                  rsp_in.outcome = hit_l2 ? tlc_pkg::OUT_L2_HIT : tlc_pkg::OUT_L2_MISS;
                  rsp_in.l2_way = way;
                  // prefetch next block
                  if (sb_cnt == CB'(D)) begin
                     for (int i = 0; i < D-1; i++) sb[i] = sb[i+1];
                     sb[D-1] = SB'(blk_ff) + 1'b1;
                  end else begin
                     sb[sb_cnt[tlc_pkg::PosBits-1:0]] = SB'(blk_ff) + 1'b1;
                     sb_cnt = sb_cnt + 1'b1;
                  end
               end
            end
            l1_fill = 1'b1;
            if (inst_ff) begin
               isb_in = sb; isb_cnt_in = sb_cnt;
            end else begin
               dsb_in = sb; dsb_cnt_in = sb_cnt;
            end
         end

         if (l1_fill) begin
            l1_we = 1'b1;
            l1_wdata = {1'b1, wr_ff, blk_ff};
            if (l1_v && l1_d) begin
               rsp_in.l1_eviction = tlc_pkg::EVICT_WRITE;
               if (wc == CB'(D)) begin
                  rsp_in.writeback_valid = 1'b1;
                  rsp_in.writeback_block = wv[0];
                  for (int i = 0; i < D-1; i++) wv[i] = wv[i+1];
                  wv[D-1] = l1_tag;
               end else begin
                  wv[wc[tlc_pkg::PosBits-1:0]] = l1_tag;
                  wc = wc + 1'b1;
               end
               wbq_in = wv; wbq_cnt_in = wc;
            end else if (l1_v) begin
               rsp_in.l1_eviction = tlc_pkg::EVICT_VICTIM;
               if (vic_cnt_in == CB'(D)) begin
                  for (int i = 0; i < D-1; i++) vic_in[i] = vic_in[i+1];
                  vic_in[D-1] = l1_tag;
               end else begin
                  vic_in[vic_cnt_in[tlc_pkg::PosBits-1:0]] = l1_tag;
                  vic_cnt_in = vic_cnt_in + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         vic_cnt_ff <= '0;
         wbq_cnt_ff <= '0;
         isb_cnt_ff <= '0;
         dsb_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         vic_cnt_ff <= vic_cnt_in;
         wbq_cnt_ff <= wbq_cnt_in;
         isb_cnt_ff <= isb_cnt_in;
         dsb_cnt_ff <= dsb_cnt_in;
      end
      blk_ff  <= blk_in;
      inst_ff <= inst_in;
      wr_ff   <= wr_in;
      vic_ff  <= vic_in;
      wbq_ff  <= wbq_in;
      isb_ff  <= isb_in;
      dsb_ff  <= dsb_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_word = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      vic_cnt_ff <= CB'(D) && wbq_cnt_ff <= CB'(D) && isb_cnt_ff <= CB'(D)
      && dsb_cnt_ff <= CB'(D)) else $error("fifo count overflow");
   a_wb_only_dirty: assert property (@(posedge clock) disable iff (reset)
      cmd.resolve && rsp_in.writeback_valid |-> rsp_in.l1_eviction == tlc_pkg::EVICT_WRITE)
      else $error("writeback without dirty eviction");
   a_wb_full: assert property (@(posedge clock) disable iff (reset)
      cmd.resolve && rsp_in.writeback_valid |-> wbq_cnt_ff == CB'(D))
      else $error("writeback with buffer not full");
endmodule

FILE: sv/two_level_cache_victim_prefetch_top.sv
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req_word (address, is_instruction, is_write)
// result  | rsp_valid | rsp_stall | rsp_word (outcome, eviction, writeback, l2_way)
//
// An accepted word reaches its result through the tag RAM read, resolve/write-back
// and the result register; the reads of the L1 and L2 tag RAMs are registered.
// A new word is accepted in the cycle its predecessor's result is taken, so
// only one word is in flight at a time. After reset a clearing pass (one L1 line
// and one L2 set per cycle for 256 rows, then one more row write) runs;
// req_stall stays high meanwhile.
// rsp_stall holds the result register and blocks new requests.
module two_level_cache_victim_prefetch_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tlc_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tlc_pkg::rsp_type rsp_word
);
   tlc_pkg::cmd_type cmd;
   tlc_pkg::sts_type sts;

   // sequencer: clear pass, read, resolve, present
   tlc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts);

   // tag RAMs, small queues and the lookup/replace logic
   tlc_dp u_dp (
      .clock, .reset, .req_word, .rsp_word, .cmd, .sts);
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

// Cache tag pipeline bench: a behavioral tag model predicts the outcome of
// every access word; a monitor checks each result word against the oldest
// prediction. Named tests run in order from one initial block.
module tb_top;

   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tlc_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tlc_pkg::rsp_type rsp_word;

   two_level_cache_victim_prefetch_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Tag model state
   // ---------------------------------------------------------------
   logic                        l1_vld [tlc_pkg::L1Lines];
   logic                        l1_dty [tlc_pkg::L1Lines];
   logic [tlc_pkg::BlkBits-1:0] l1_tag [tlc_pkg::L1Lines];
   logic                        l2_vld [tlc_pkg::L2Sets][tlc_pkg::Ways];
   logic [tlc_pkg::BlkBits-1:0] l2_tag [tlc_pkg::L2Sets][tlc_pkg::Ways];
   int                          l2_age [tlc_pkg::L2Sets][tlc_pkg::Ways];
   // queues: oldest at index 0; entries are one bit wider than a block (blk+1 in the streams)
   logic [tlc_pkg::SbBits-1:0] victim_q[$];
   logic [tlc_pkg::SbBits-1:0] istream_q[$];
   logic [tlc_pkg::SbBits-1:0] dstream_q[$];
   logic [tlc_pkg::SbBits-1:0] wrbuf_q[$];

   tlc_pkg::rsp_type expected_rsp[$];
   int      fail_count = 0;

   logic idle_on = 1'b1;   // random gaps and result stalls enabled
   longint cycles = 0;
   int     stall_left = 0;

   task automatic model_reset();
      for (int i = 0; i < tlc_pkg::L1Lines; i++) begin
         l1_vld[i] = 1'b0; l1_dty[i] = 1'b0; l1_tag[i] = '0;
      end
      for (int s = 0; s < tlc_pkg::L2Sets; s++) begin
         for (int w = 0; w < tlc_pkg::Ways; w++) begin
            l2_vld[s][w] = 1'b0; l2_tag[s][w] = '0; l2_age[s][w] = w;
         end
      end
      victim_q.delete(); istream_q.delete(); dstream_q.delete(); wrbuf_q.delete();
   endtask

   // push with silent drop of the oldest when full; returns whether one was dropped, outputs it
   function automatic bit queue_push(ref logic [tlc_pkg::SbBits-1:0] q[$],
                                     input logic [tlc_pkg::SbBits-1:0] v,
                                     output logic [tlc_pkg::SbBits-1:0] dropped);
      bit full;
      full = (q.size() >= tlc_pkg::BufDepth);
      dropped = '0;
      if (full) begin
         dropped = q[0];
         q.delete(0);
      end
      q = {q, v};
      return full;
   endfunction

   function automatic int queue_find(ref logic [tlc_pkg::SbBits-1:0] q[$],
                                     input logic [tlc_pkg::SbBits-1:0] v);
      for (int i = 0; i < q.size(); i++)
         if (q[i] == v) return i;
      return -1;
   endfunction

   function automatic void lru_touch(int s, int w);
      int prev;
      prev = l2_age[s][w];
      for (int i = 0; i < tlc_pkg::Ways; i++)
         if (l2_age[s][i] < prev) l2_age[s][i]++;
      l2_age[s][w] = 0;
   endfunction

   // Install blk in L1 line li, spilling the old line to victim or write buffer.
   function automatic void l1_refill(int li, logic [tlc_pkg::BlkBits-1:0] blk, bit wr,
                                     inout tlc_pkg::rsp_type r);
      logic [tlc_pkg::SbBits-1:0] dropped;
      if (l1_vld[li]) begin
         if (l1_dty[li]) begin
            r.l1_eviction = tlc_pkg::EVICT_WRITE;
            if (queue_push(wrbuf_q, {1'b0, l1_tag[li]}, dropped)) begin
               r.writeback_valid = 1'b1;
               r.writeback_block = dropped[tlc_pkg::BlkBits-1:0];
            end
         end else begin
            r.l1_eviction = tlc_pkg::EVICT_VICTIM;
            void'(queue_push(victim_q, {1'b0, l1_tag[li]}, dropped));
         end
      end
      l1_vld[li] = 1'b1; l1_dty[li] = wr; l1_tag[li] = blk;
   endfunction

   function automatic tlc_pkg::rsp_type cache_lookup(tlc_pkg::req_type a);
      tlc_pkg::rsp_type r;
      logic [tlc_pkg::BlkBits-1:0] blk;
      logic [tlc_pkg::SbBits-1:0] dropped;
      int li, si, pos, vw;
      r = '0;
      blk = a.address[tlc_pkg::AddrBits-1:tlc_pkg::OffBits];
      li = blk % tlc_pkg::L1Lines;
      si = blk % tlc_pkg::L2Sets;
      if (l1_vld[li] && l1_tag[li] == blk) begin
         if (a.is_write) l1_dty[li] = 1'b1;
         r.outcome = tlc_pkg::OUT_L1_HIT;
         return r;
      end
      pos = queue_find(victim_q, {1'b0, blk});
      if (pos >= 0) begin
         victim_q.delete(pos);
         l1_refill(li, blk, a.is_write, r);
         r.outcome = tlc_pkg::OUT_VIC_HIT;
         return r;
      end
      pos = a.is_instruction ? queue_find(istream_q, {1'b0, blk})
                             : queue_find(dstream_q, {1'b0, blk});
      if (pos >= 0) begin
         if (a.is_instruction) istream_q.delete(pos); else dstream_q.delete(pos);
         l1_refill(li, blk, a.is_write, r);
         r.outcome = tlc_pkg::OUT_SB_HIT;
         return r;
      end
      vw = -1;
      for (int w = 0; w < tlc_pkg::Ways; w++)
         if (vw < 0 && l2_vld[si][w] && l2_tag[si][w] == blk) vw = w;
      if (vw >= 0) begin
         r.outcome = tlc_pkg::OUT_L2_HIT;
      end else begin
         for (int w = tlc_pkg::Ways - 1; w >= 0; w--)
            if (!l2_vld[si][w]) vw = w;
         if (vw < 0) begin
            vw = 0;
            for (int w = tlc_pkg::Ways - 1; w >= 0; w--)
               if (l2_age[si][w] == tlc_pkg::Ways - 1) vw = w;
         end
         l2_vld[si][vw] = 1'b1;
         l2_tag[si][vw] = blk;
         r.outcome = tlc_pkg::OUT_L2_MISS;
      end
      lru_touch(si, vw);
      l1_refill(li, blk, a.is_write, r);
      // next-block prefetch; top block prefetches an unmatched 4096
      if (a.is_instruction) void'(queue_push(istream_q, {1'b0, blk} + 1'b1, dropped));
      else void'(queue_push(dstream_q, {1'b0, blk} + 1'b1, dropped));
      r.l2_way = vw[tlc_pkg::WayBits-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Driver: one word per call, random gap bursts before it; valid
   // stays high after acceptance until a gap or a drain drops it
   // ---------------------------------------------------------------
   task automatic send_access(logic [15:0] addr, bit instr, bit wr);
      tlc_pkg::req_type w;
      tlc_pkg::rsp_type p;
      if (idle_on && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      w.address = addr; w.is_instruction = instr; w.is_write = wr;
      req_word <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      p = cache_lookup(w);
      expected_rsp = {expected_rsp, p};
   endtask

   // Result stall bursts, started at random while gaps are enabled
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= int'($urandom_range(2, 0));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      tlc_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            fail_count++;
         end else begin
            e = expected_rsp[0];
            expected_rsp.delete(0);
            if (rsp_word.outcome !== e.outcome) begin
               $error("outcome exp %0d got %0d", e.outcome, rsp_word.outcome);
               fail_count++;
            end
            if (rsp_word.l1_eviction !== e.l1_eviction) begin
               $error("l1_eviction exp %0d got %0d", e.l1_eviction, rsp_word.l1_eviction);
               fail_count++;
            end
            if (rsp_word.writeback_valid !== e.writeback_valid) begin
               $error("writeback_valid exp %0d got %0d",
                      e.writeback_valid, rsp_word.writeback_valid);
               fail_count++;
            end
            if (rsp_word.writeback_block !== e.writeback_block) begin
               $error("writeback_block exp %0d got %0d",
                      e.writeback_block, rsp_word.writeback_block);
               fail_count++;
            end
            if (rsp_word.l2_way !== e.l2_way) begin
               $error("l2_way exp %0d got %0d", e.l2_way, rsp_word.l2_way);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Address extremes, L1 hit, write then dirty eviction
   task automatic test_extremes();
      send_access(16'h0000, 0, 0);   // miss, way 0
      send_access(16'h000F, 0, 1);   // L1 hit, line goes dirty
      send_access(16'hFFFF, 1, 0);   // top block: prefetch past the top
      send_access(16'hFFF0, 1, 1);   // L1 hit
      send_access(16'h0800, 0, 0);   // same L1 line as 0: dirty evict
   endtask

   // Victim hit, stream hit, L2 hit, LRU fill of one set
   task automatic test_paths();
      send_access(16'h0000, 0, 0);   // L2 hit, block 0 sits in the write buffer
      send_access(16'h0010, 0, 0);   // data stream hit on block 1
      send_access(16'h0810, 0, 0);   // evicts clean block 1 to victim
      send_access(16'h0010, 0, 0);   // victim hit
      // five blocks in L2 set 5 force LRU replacement
      for (int k = 0; k < 5; k++) send_access(16'(((k * 256) + 5) * 16), k[0], 0);
      send_access(16'h0050, 1, 0);   // victim hit: block 5 is still in the victim queue
   endtask

   // Fill write buffer with dirty lines to force write-backs
   task automatic test_writeback();
      for (int k = 0; k < 8; k++) begin
         send_access(16'((k * 128 + 9) * 16), 0, 1);
      end
   endtask

   // Random: mostly a small working set so all hit paths and overflow occur
   task automatic test_random(int n);
      logic [15:0] a;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: a = 16'($urandom);
            1: a = {3'($urandom_range(7)), 4'b0, 5'($urandom_range(3)), 4'($urandom)};
            default: a = {3'($urandom_range(7)), 5'b0, 4'($urandom_range(7)), 4'($urandom)};
         endcase
         if (i == n / 2) wait_drained();   // pause until all results are in
         send_access(a, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_paths();
      test_writeback();
      test_random(600);
      idle_on <= 1'b0;    // no gaps or result stalls at the tail
      test_random(130);
      wait_drained();
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
